### rtl/core/ssq_pkg.sv
// Shared types and codes for the stable sorted priority queue core.
// No dependencies; imported by the channel interfaces and all core modules.
package ssq_pkg;

   localparam int DATA_W = 8;
   localparam int PRI_W  = 8;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              load;
      logic              insert;
      logic              remove;
      logic              front;
      logic [STAT_W-1:0] status;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

### rtl/core/ssq_channels.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on ssq_pkg for field widths.
interface ssq_req_if import ssq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [DATA_W-1:0] item_data;
   logic [PRI_W-1:0]  item_priority;

   modport source (output valid, cmd, item_data, item_priority, input ready);
   modport sink   (input valid, cmd, item_data, item_priority, output ready);
endinterface

interface ssq_rsp_if import ssq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_data;
   logic [STAT_W-1:0] status;
   logic [OCC_W-1:0]  occupancy;
   logic              now_empty;

   modport source (output valid, out_data, status, occupancy, now_empty, input ready);
   modport sink   (input valid, out_data, status, occupancy, now_empty, output ready);
endinterface

### rtl/core/ssq_ctrl.sv
// Transaction controller: handshake, command decode and response valid state.
// Depends on ssq_pkg; drives the datapath command struct.
module ssq_ctrl import ssq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dp_stat_type      dp_stat,
   output ctl_cmd_type      dp_cmd
);

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_HOLD);

   always_comb begin
      dp_cmd        = '0;
      dp_cmd.load   = accept;
      dp_cmd.status = ST_OK;
      case (req_cmd)
         CMD_PUSH: begin
            if (dp_stat.full) begin
               dp_cmd.status = ST_FULL;
            end else begin
               dp_cmd.insert = accept;
            end
         end
         CMD_POP: begin
            if (dp_stat.empty) begin
               dp_cmd.status = ST_EMPTY;
            end else begin
               dp_cmd.remove = accept;
               dp_cmd.front  = 1'b1;
            end
         end
         CMD_PEEK: begin
            if (dp_stat.empty) begin
               dp_cmd.status = ST_EMPTY;
            end else begin
               dp_cmd.front = 1'b1;
            end
         end
         default: begin
            dp_cmd.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = S_HOLD;
      end else if (rsp_ready) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.insert && dp_cmd.remove))
      else $error("insert and remove issued together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

endmodule

### rtl/core/ssq_datapath.sv
// Sorted entry array with per-cell compare and shift, occupancy and result registers.
// Depends on ssq_pkg; commanded by ssq_ctrl.
module ssq_datapath import ssq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       dp_cmd,
   input  logic [DATA_W-1:0] item_data,
   input  logic [PRI_W-1:0]  item_priority,
   output dp_stat_type       dp_stat,
   output logic [DATA_W-1:0] out_data,
   output logic [STAT_W-1:0] status,
   output logic [OCC_W-1:0]  occupancy,
   output logic              now_empty
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] data_ff [DEPTH];
   logic [PRI_W-1:0]  pri_ff  [DEPTH];
   logic [DEPTH-1:0]  gt;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] out_data_ff;
   logic [STAT_W-1:0] status_ff;
   logic [OCC_W-1:0]  occupancy_ff;
   logic              now_empty_ff;

   assign dp_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign dp_stat.empty = (count_ff == '0);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign gt[i] = (CNT_W'(i) < count_ff) && (pri_ff[i] > item_priority);

      logic take_prev;
      logic take_new;
      logic take_next;

      if (i == 0) begin : g_first
         assign take_prev = 1'b0;
         assign take_new  = gt[i] || (count_ff == '0);
      end else begin : g_rest
         assign take_prev = gt[i-1];
         assign take_new  = !gt[i-1] && (gt[i] || (count_ff == CNT_W'(i)));
      end

      if (i == DEPTH - 1) begin : g_last
         assign take_next = 1'b0;
      end else begin : g_inner
         assign take_next = 1'b1;
      end

      always_ff @(posedge clock) begin
         if (dp_cmd.insert) begin
            if (take_prev) begin
               if (i > 0) begin
                  data_ff[i] <= data_ff[(i > 0) ? i - 1 : 0];
                  pri_ff[i]  <= pri_ff[(i > 0) ? i - 1 : 0];
               end
            end else if (take_new) begin
               data_ff[i] <= item_data;
               pri_ff[i]  <= item_priority;
            end
         end else if (dp_cmd.remove && take_next) begin
            data_ff[i] <= data_ff[(i < DEPTH - 1) ? i + 1 : i];
            pri_ff[i]  <= pri_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (dp_cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (dp_cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         out_data_ff  <= dp_cmd.front ? data_ff[0] : '0;
         status_ff    <= dp_cmd.status;
         occupancy_ff <= OCC_W'(count_in);
         now_empty_ff <= (count_in == '0);
      end
   end

   assign out_data  = out_data_ff;
   assign status    = status_ff;
   assign occupancy = occupancy_ff;
   assign now_empty = now_empty_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance occupancy");

   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.remove |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("remove did not drop occupancy");

endmodule

### rtl/core/stable_sorted_priority_queue_core.sv
// Top level of the stable sorted priority queue: controller plus datapath.
// Depends on ssq_pkg, ssq_channels, ssq_ctrl and ssq_datapath.
//
//   channel   dir  fields
//   req_chan  in   cmd, item_data, item_priority
//   rsp_chan  out  out_data, status, occupancy, now_empty
//
// One transaction per cycle while responses are taken: each request updates the
// cell array at its accepting edge, which also loads the response register; the
// response is offered the next cycle. Per-cell compare and shift sets that figure.
// Reset clears occupancy and the response valid state only.
// A stalled response blocks new requests; a response taken in the same cycle
// lets the next request in without a bubble.
module stable_sorted_priority_queue_core import ssq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   ssq_req_if.sink   req_chan,
   ssq_rsp_if.source rsp_chan
);

   ctl_cmd_type dp_cmd;
   dp_stat_type dp_stat;

   ssq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_cmd   (req_chan.cmd),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   ssq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .item_data     (req_chan.item_data),
      .item_priority (req_chan.item_priority),
      .dp_stat       (dp_stat),
      .out_data      (rsp_chan.out_data),
      .status        (rsp_chan.status),
      .occupancy     (rsp_chan.occupancy),
      .now_empty     (rsp_chan.now_empty)
   );

endmodule
